/* rtl/gdfw_pkg.sv */
// gdfw_pkg: shared types, codes and constants of the depth-first walk unit
`timescale 1ns / 1ps

package gdfw_pkg;

  localparam int GDFW_MAX_NODES = 32;

  localparam logic [6:0] NODE_COUNT_RESET = 7'd32;

  // operation codes
  localparam logic [1:0] OP_LINK  = 2'd0;
  localparam logic [1:0] OP_WALK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [6:0] first_node;
    logic [6:0] second_node;
  } gdfw_in_word_t;

  typedef struct packed {
    logic [6:0] node_number;
    logic [1:0] status;
    logic       last;
  } gdfw_out_word_t;

  typedef enum logic [1:0] {
    EMIT_NONE      = 2'd0,
    EMIT_STATUS    = 2'd1,
    EMIT_PEND      = 2'd2,
    EMIT_PEND_LAST = 2'd3
  } gdfw_emit_t;

  typedef struct packed {
    logic       link_latch;
    logic       link_read_q;
    logic       link_write_p;
    logic       link_write_q;
    logic       walk_init;
    logic       walk_load;
    logic       fetch;
    logic       pop;
    logic       load_top;
    logic       visit;
    logic       push;
    logic       clear_graph;
    gdfw_emit_t emit;
    logic [1:0] emit_status;
  } gdfw_cmd_t;

  typedef struct packed {
    logic link_range_ok;
    logic walk_range_ok;
    logic link_full;
    logic nbr_more;
    logic nbr_seen;
    logic depth_one;
  } gdfw_sts_t;

endpackage

/* rtl/gdfw_ram.sv */
// gdfw_ram: generic single write port ram with one registered read port
`timescale 1ns / 1ps

module gdfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/gdfw_ctrl.sv */
// gdfw_ctrl: sequencer for link insertion, clear and depth-first walk
`timescale 1ns / 1ps

module gdfw_ctrl
  import gdfw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] op,
  input  gdfw_sts_t  sts,
  output logic       busy,
  output gdfw_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_LA     = 9'b000000010,
    S_LB     = 9'b000000100,
    S_LC     = 9'b000001000,
    S_WSTART = 9'b000010000,
    S_FETCH  = 9'b000100000,
    S_NBR    = 9'b001000000,
    S_PUSH   = 9'b010000000,
    S_POP    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.emit = EMIT_NONE;
    cmd.emit_status = ST_OK;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (op)
            OP_LINK: begin
              if (sts.link_range_ok) begin
                cmd.link_latch = 1'b1;
                state_nxt = S_LA;
              end else begin
                cmd.emit = EMIT_STATUS;
                cmd.emit_status = ST_RANGE;
              end
            end
            OP_WALK: begin
              if (sts.walk_range_ok) begin
                cmd.walk_init = 1'b1;
                state_nxt = S_WSTART;
              end else begin
                cmd.emit = EMIT_STATUS;
                cmd.emit_status = ST_RANGE;
              end
            end
            OP_CLEAR: begin
              cmd.clear_graph = 1'b1;
              cmd.emit = EMIT_STATUS;
              cmd.emit_status = ST_OK;
            end
            default: ;
          endcase
        end
      end
      S_LA: begin
        cmd.link_read_q = 1'b1;
        state_nxt = S_LB;
      end
      S_LB: begin
        if (sts.link_full) begin
          cmd.emit = EMIT_STATUS;
          cmd.emit_status = ST_FULL;
          state_nxt = S_IDLE;
        end else begin
          cmd.link_write_p = 1'b1;
          state_nxt = S_LC;
        end
      end
      S_LC: begin
        cmd.link_write_q = 1'b1;
        cmd.emit = EMIT_STATUS;
        cmd.emit_status = ST_OK;
        state_nxt = S_IDLE;
      end
      S_WSTART: begin
        cmd.walk_load = 1'b1;
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        if (sts.nbr_more) begin
          cmd.fetch = 1'b1;
          state_nxt = S_NBR;
        end else if (sts.depth_one) begin
          cmd.emit = EMIT_PEND_LAST;
          state_nxt = S_IDLE;
        end else begin
          cmd.pop = 1'b1;
          state_nxt = S_POP;
        end
      end
      S_NBR: begin
        if (sts.nbr_seen) begin
          state_nxt = S_FETCH;
        end else begin
          cmd.visit = 1'b1;
          cmd.emit = EMIT_PEND;
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push = 1'b1;
        state_nxt = S_FETCH;
      end
      S_POP: begin
        cmd.load_top = 1'b1;
        state_nxt = S_FETCH;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_lb_after_la: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LB |-> $past(state_r) == S_LA)
    else $error("link check entered without degree read");

  a_push_after_nbr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PUSH |-> $past(state_r) == S_NBR)
    else $error("push without a fresh visit");

  a_pop_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP |-> $past(state_r) == S_FETCH)
    else $error("stack reload without a pop");

endmodule

/* rtl/gdfw_dpath.sv */
// gdfw_dpath: lists, degrees, visited marks, walk stack and result register
`timescale 1ns / 1ps

module gdfw_dpath
  import gdfw_pkg::*;
#(
  parameter int MAX_NODES = GDFW_MAX_NODES
) (
  input  logic           clk,
  input  logic           rst_n,
  input  gdfw_in_word_t  in_word,
  input  logic           cfg_we,
  input  logic [6:0]     cfg_wdata,
  input  gdfw_cmd_t      cmd,
  output gdfw_sts_t      sts,
  output logic           out_strobe,
  output gdfw_out_word_t out_word
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int DW = $clog2(MAX_NODES + 1);
  localparam int AW = $clog2(MAX_NODES * MAX_NODES);
  localparam int SW = NW + DW + DW;
  localparam logic [6:0] MAX_N7 = 7'(MAX_NODES);

  function automatic logic [AW-1:0] nbr_addr(input logic [NW-1:0] v, input logic [DW-1:0] i);
    return AW'(v) * AW'(MAX_NODES) + AW'(i);
  endfunction

  logic [6:0]           node_count_r;
  logic [6:0]           n_use;
  logic [6:0]           first_m1, second_m1;
  logic [NW-1:0]        p_idx, q_idx;
  logic [NW-1:0]        p_r, q_r;
  logic [DW-1:0]        dp_r, dq_r;
  logic [NW-1:0]        top_node_r, pend_node_r;
  logic [DW-1:0]        top_pos_r, top_deg_r;
  logic [DW-1:0]        depth_r, depth_m1, depth_m2;
  logic [MAX_NODES-1:0] visited_r, visited_nxt;
  logic [MAX_NODES-1:0] deg_valid_r, deg_valid_nxt;
  logic                 deg_rvalid_r;
  logic                 self_loop;
  logic [7:0]           n8, dp8, dq8;

  // degree ram
  logic                 deg_we;
  logic [NW-1:0]        deg_waddr, deg_raddr;
  logic [DW-1:0]        deg_wdata, deg_rdata, deg_rd;

  // neighbor ram
  logic                 nbr_we;
  logic [AW-1:0]        nbr_waddr, nbr_raddr;
  logic [NW-1:0]        nbr_wdata, nbr_w;
  logic [NW-1:0]        nbr_rdata;

  // stack ram
  logic [SW-1:0]        stk_rdata;

  logic                 out_strobe_r;
  gdfw_out_word_t       out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RESET;
    end else if (cfg_we) begin
      node_count_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (node_count_r == 7'd0) begin
      n_use = 7'd1;
    end else if (node_count_r > MAX_N7) begin
      n_use = MAX_N7;
    end else begin
      n_use = node_count_r;
    end
  end

  assign first_m1  = in_word.first_node - 7'd1;
  assign second_m1 = in_word.second_node - 7'd1;
  assign p_idx     = first_m1[NW-1:0];
  assign q_idx     = second_m1[NW-1:0];

  assign sts.walk_range_ok = (in_word.first_node != 7'd0) && (in_word.first_node <= n_use);
  assign sts.link_range_ok = sts.walk_range_ok && (in_word.second_node != 7'd0) &&
                             (in_word.second_node <= n_use);

  // degree read, entries not written since the last clear read as zero
  assign deg_rd = deg_rvalid_r ? deg_rdata : '0;

  assign self_loop = (p_r == q_r);
  assign n8  = {1'b0, n_use};
  assign dp8 = 8'(dp_r);
  assign dq8 = 8'(deg_rd);
  assign sts.link_full = self_loop ? (dp8 + 8'd2 > n8)
                                   : ((dp8 + 8'd1 > n8) || (dq8 + 8'd1 > n8));

  assign nbr_w         = nbr_rdata;
  assign sts.nbr_more  = (top_pos_r < top_deg_r);
  assign sts.nbr_seen  = visited_r[nbr_w];
  assign sts.depth_one = (depth_r == DW'(1));

  always_comb begin
    deg_raddr = '0;
    if (cmd.link_latch || cmd.walk_init) begin
      deg_raddr = p_idx;
    end else if (cmd.link_read_q) begin
      deg_raddr = q_r;
    end else if (cmd.visit) begin
      deg_raddr = nbr_w;
    end
  end

  always_comb begin
    deg_we    = cmd.link_write_p | cmd.link_write_q;
    nbr_we    = deg_we;
    if (cmd.link_write_q) begin
      deg_waddr = q_r;
      deg_wdata = dq_r + DW'(1);
      nbr_waddr = nbr_addr(q_r, dq_r);
      nbr_wdata = p_r;
    end else begin
      deg_waddr = p_r;
      deg_wdata = dp_r + DW'(1);
      nbr_waddr = nbr_addr(p_r, dp_r);
      nbr_wdata = q_r;
    end
  end

  assign nbr_raddr = nbr_addr(top_node_r, top_pos_r);

  always_comb begin
    deg_valid_nxt = deg_valid_r;
    if (cmd.clear_graph) begin
      deg_valid_nxt = '0;
    end else if (deg_we) begin
      deg_valid_nxt[deg_waddr] = 1'b1;
    end
  end

  always_comb begin
    visited_nxt = visited_r;
    if (cmd.clear_graph) begin
      visited_nxt = '0;
    end else if (cmd.walk_init) begin
      visited_nxt = '0;
      visited_nxt[p_idx] = 1'b1;
    end else if (cmd.visit) begin
      visited_nxt[nbr_w] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_valid_r <= '0;
      visited_r   <= '0;
    end else begin
      deg_valid_r <= deg_valid_nxt;
      visited_r   <= visited_nxt;
    end
  end

  always_ff @(posedge clk) begin
    deg_rvalid_r <= deg_valid_r[deg_raddr];
  end

  assign depth_m1 = depth_r - DW'(1);
  assign depth_m2 = depth_r - DW'(2);

  // link and walk working registers
  always_ff @(posedge clk) begin
    if (cmd.link_latch) begin
      p_r <= p_idx;
      q_r <= q_idx;
    end
    if (cmd.link_read_q) begin
      dp_r <= deg_rd;
    end
    if (cmd.link_write_p) begin
      dq_r <= self_loop ? dp_r + DW'(1) : deg_rd;
    end
    if (cmd.walk_init) begin
      pend_node_r <= p_idx;
      top_node_r  <= p_idx;
    end
    if (cmd.walk_load) begin
      top_pos_r <= '0;
      top_deg_r <= deg_rd;
      depth_r   <= DW'(1);
    end
    if (cmd.fetch) begin
      top_pos_r <= top_pos_r + DW'(1);
    end
    if (cmd.visit) begin
      pend_node_r <= nbr_w;
      top_node_r  <= nbr_w;
    end
    if (cmd.push) begin
      top_pos_r <= '0;
      top_deg_r <= deg_rd;
      depth_r   <= depth_r + DW'(1);
    end
    if (cmd.pop) begin
      depth_r <= depth_m1;
    end
    if (cmd.load_top) begin
      {top_node_r, top_pos_r, top_deg_r} <= stk_rdata;
    end
  end

  gdfw_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_deg_ram (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr),
    .wdata (deg_wdata),
    .raddr (deg_raddr),
    .rdata (deg_rdata)
  );

  gdfw_ram #(.WIDTH(NW), .DEPTH(MAX_NODES * MAX_NODES)) u_nbr_ram (
    .clk   (clk),
    .we    (nbr_we),
    .waddr (nbr_waddr),
    .wdata (nbr_wdata),
    .raddr (nbr_raddr),
    .rdata (nbr_rdata)
  );

  // entries below the top; the top itself lives in top_*_r
  gdfw_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_stk_ram (
    .clk   (clk),
    .we    (cmd.visit),
    .waddr (depth_m1[NW-1:0]),
    .wdata ({top_node_r, top_pos_r, top_deg_r}),
    .raddr (depth_m2[NW-1:0]),
    .rdata (stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (cmd.emit != EMIT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      EMIT_STATUS: begin
        out_word_r.node_number <= 7'd0;
        out_word_r.status      <= cmd.emit_status;
        out_word_r.last        <= 1'b1;
      end
      EMIT_PEND, EMIT_PEND_LAST: begin
        out_word_r.node_number <= 7'(pend_node_r) + 7'd1;
        out_word_r.status      <= ST_OK;
        out_word_r.last        <= (cmd.emit == EMIT_PEND_LAST);
      end
      default: ;
    endcase
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  a_fetch_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fetch |-> top_pos_r < top_deg_r)
    else $error("neighbor fetch past end of list");

  a_visit_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.visit |-> !visited_r[nbr_w])
    else $error("node visited twice");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> depth_r > DW'(1))
    else $error("pop would empty the stack");

endmodule

/* rtl/graph_depth_first_walk_unit.sv */
// graph_depth_first_walk_unit: adjacency-list graph store with depth-first walk
// a word is registered and comes out in the cycle after the step that makes it; clear,
//   a bad node number and an ignored operation are handled in idle, a link steps through
//   LA, LB and, unless full, LC; a walk steps through fetch, neighbor, push and pop states,
//   paced by the single read port of the neighbor, degree and stack rams
// the receiver cannot stall: each out_strobe word is valid for exactly one cycle
// reset (rst_n low, synchronous): node_count to 32, all lists and marks empty, no sweep
`timescale 1ns / 1ps

module graph_depth_first_walk_unit
  import gdfw_pkg::*;
#(
  parameter int MAX_NODES = GDFW_MAX_NODES
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  gdfw_in_word_t  in_word,
  output logic           out_strobe,
  output gdfw_out_word_t out_word,
  input  logic           cfg_we,
  input  logic [6:0]     cfg_wdata
);

  // command and status between sequencer and datapath
  gdfw_cmd_t cmd;
  gdfw_sts_t sts;

  // sequencer: one-hot fsm, idle accepts a word whenever start is high
  gdfw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_word.operation),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  // datapath: neighbor ram, degree ram with valid flops, visited flops,
  // stack ram with cached top entry, pending-visit and result registers
  gdfw_dpath #(.MAX_NODES(MAX_NODES)) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule
